// ===== hdl/ccal_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccal_pkg: shared types and constants
// Register indexes, configuration and item structures and calendar limits
// for the clock/calendar key controller.
// ----------------------------------------------------------------------------
package ccal_pkg;

	localparam int CfgIndexW = 2;
	localparam int CfgDataW  = 16;
	localparam int InDataW   = 64;
	localparam int OutDataW  = 24;

	typedef enum logic [CfgIndexW-1:0] {
		REG_KEYS_ACTIVE_LOW    = 2'd0,
		REG_SHORT_PRESS_MIN_MS = 2'd1,
		REG_SHORT_PRESS_MAX_MS = 2'd2,
		REG_NAV_LOCKOUT_MS     = 2'd3
	} cfg_reg_t;

	localparam logic        KEYS_ACTIVE_LOW_RST = 1'b1;
	localparam logic [15:0] SHORT_MIN_RST       = 16'd20;
	localparam logic [15:0] SHORT_MAX_RST       = 16'd900;
	localparam logic [15:0] NAV_LOCKOUT_RST     = 16'd280;

	localparam logic [11:0] YEAR_BASE      = 12'd2000;
	localparam logic [6:0]  YEAR_OFS_MAX   = 7'd99;
	localparam logic [6:0]  CENTURY        = 7'd100;
	localparam logic [3:0]  MONTH_FIRST    = 4'd1;
	localparam logic [3:0]  MONTH_LAST     = 4'd12;
	localparam logic [7:0]  SECOND_NONE    = 8'd255;

	typedef struct packed {
		logic        keys_active_low;
		logic [15:0] short_press_min_ms;
		logic [15:0] short_press_max_ms;
		logic [15:0] nav_lockout_ms;
	} cfg_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        clock_read_ok;
		logic        mode_key_level;
		logic        back_key_level;
		logic        forward_key_level;
		logic [6:0]  clock_year;
		logic [3:0]  clock_month;
		logic [4:0]  clock_day;
		logic [5:0]  clock_second;
		logic        sync_done;
	} item_t;

	typedef struct packed {
		logic        in_month_view;
		logic [11:0] shown_year;
		logic [3:0]  shown_month;
		logic        repaint_month;
		logic        repaint_dial;
		logic        resync_hands;
		logic        advance_hands;
		logic        refresh_date_panel;
	} result_t;

endpackage

// ===== hdl/ccal_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccal_cfg: configuration registers
// Holds the key polarity and the press and lockout timing registers.
// ----------------------------------------------------------------------------
module ccal_cfg
	import ccal_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [CfgDataW-1:0]  cfg_wdata,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.keys_active_low    <= KEYS_ACTIVE_LOW_RST;
			cfg_q.short_press_min_ms <= SHORT_MIN_RST;
			cfg_q.short_press_max_ms <= SHORT_MAX_RST;
			cfg_q.nav_lockout_ms     <= NAV_LOCKOUT_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_KEYS_ACTIVE_LOW:    cfg_q.keys_active_low    <= cfg_wdata[0];
				REG_SHORT_PRESS_MIN_MS: cfg_q.short_press_min_ms <= cfg_wdata;
				REG_SHORT_PRESS_MAX_MS: cfg_q.short_press_max_ms <= cfg_wdata;
				REG_NAV_LOCKOUT_MS:     cfg_q.nav_lockout_ms     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/ccal_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccal_core: controller state and tick logic
// Updates the mode, viewed month, key history, snapshot and drawn-second
// state for one poll tick and forms that tick's result.
// ----------------------------------------------------------------------------
module ccal_core
	import ccal_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  cfg_t    cfg,
	input  item_t   item,
	output result_t res
);

	logic        mode_q, mode_n;
	logic [6:0]  year_ofs_q, year_ofs_n;
	logic [3:0]  disp_month_q, disp_month_n;
	logic        mode_was_q, back_was_q, fwd_was_q;
	logic [31:0] press_start_q, press_start_n;
	logic [31:0] last_step_q, last_step_n;
	logic        snap_valid_q, snap_valid_n;
	logic [6:0]  snap_year_q, snap_year_n;
	logic [3:0]  snap_month_q, snap_month_n;
	logic [4:0]  snap_day_q, snap_day_n;
	logic [7:0]  drawn_sec_q, drawn_sec_n;

	logic        mk, bk, fk;
	logic [31:0] hold_ms;
	logic [31:0] since_step;
	logic        toggle;
	logic        back_step, fwd_step;
	logic [6:0]  year_mod;
	logic [3:0]  month_clamp;
	logic [7:0]  sec_ext;
	logic        rep_month, rep_dial, resync, advance, panel;

	assign mk = item.mode_key_level ^ cfg.keys_active_low;
	assign bk = item.back_key_level ^ cfg.keys_active_low;
	assign fk = item.forward_key_level ^ cfg.keys_active_low;

	assign hold_ms    = item.now_ms - press_start_q;
	assign since_step = item.now_ms - last_step_q;
	assign sec_ext    = {2'b00, item.clock_second};
	assign year_mod   = (item.clock_year >= CENTURY) ? item.clock_year - CENTURY
	                                                 : item.clock_year;
	assign month_clamp = (item.clock_month < MONTH_FIRST) ? MONTH_FIRST :
	                     (item.clock_month > MONTH_LAST)  ? MONTH_LAST  : item.clock_month;

	assign toggle = !mk && mode_was_q &&
	                (hold_ms >= {16'd0, cfg.short_press_min_ms}) &&
	                (hold_ms <  {16'd0, cfg.short_press_max_ms});

	always_comb begin
		mode_n        = mode_q;
		year_ofs_n    = year_ofs_q;
		disp_month_n  = disp_month_q;
		press_start_n = press_start_q;
		last_step_n   = last_step_q;
		snap_valid_n  = snap_valid_q;
		snap_year_n   = snap_year_q;
		snap_month_n  = snap_month_q;
		snap_day_n    = snap_day_q;
		drawn_sec_n   = drawn_sec_q;
		rep_month     = 1'b0;
		rep_dial      = 1'b0;
		resync        = 1'b0;
		advance       = 1'b0;
		panel         = 1'b0;
		back_step     = 1'b0;
		fwd_step      = 1'b0;

		if (item.clock_read_ok) begin
			if (mk && !mode_was_q) begin
				press_start_n = item.now_ms;
			end
			if (toggle) begin
				if (!mode_q) begin
					mode_n       = 1'b1;
					year_ofs_n   = year_mod;
					disp_month_n = month_clamp;
					rep_month    = 1'b1;
					snap_valid_n = 1'b1;
					snap_year_n  = item.clock_year;
					snap_month_n = item.clock_month;
					snap_day_n   = item.clock_day;
				end else begin
					mode_n       = 1'b0;
					rep_dial     = 1'b1;
					resync       = 1'b1;
					drawn_sec_n  = sec_ext;
					snap_valid_n = 1'b0;
				end
			end

			if (mode_n) begin
				// A back step restarts the lockout and wins over a forward
				// step in the same tick, which is then refused.
				back_step = bk && !back_was_q && (since_step > {16'd0, cfg.nav_lockout_ms});
				fwd_step  = fk && !fwd_was_q && !back_step &&
				            (since_step > {16'd0, cfg.nav_lockout_ms});
				if (back_step) begin
					rep_month   = 1'b1;
					last_step_n = item.now_ms;
					if (disp_month_n <= MONTH_FIRST) begin
						if (year_ofs_n == 7'd0) begin
							disp_month_n = MONTH_FIRST;
						end else begin
							disp_month_n = MONTH_LAST;
							year_ofs_n   = year_ofs_n - 7'd1;
						end
					end else begin
						disp_month_n = disp_month_n - 4'd1;
					end
				end
				if (fwd_step) begin
					rep_month   = 1'b1;
					last_step_n = item.now_ms;
					if (disp_month_n >= MONTH_LAST) begin
						if (year_ofs_n >= YEAR_OFS_MAX) begin
							disp_month_n = MONTH_LAST;
							year_ofs_n   = YEAR_OFS_MAX;
						end else begin
							disp_month_n = MONTH_FIRST;
							year_ofs_n   = year_ofs_n + 7'd1;
						end
					end else begin
						disp_month_n = disp_month_n + 4'd1;
					end
				end
				if (snap_valid_n && (item.clock_year != snap_year_n ||
				    item.clock_month != snap_month_n || item.clock_day != snap_day_n)) begin
					snap_year_n  = item.clock_year;
					snap_month_n = item.clock_month;
					snap_day_n   = item.clock_day;
					rep_month    = 1'b1;
				end
			end else begin
				panel = 1'b1;
			end

			if (item.sync_done) begin
				if (!mode_n) begin
					resync      = 1'b1;
					drawn_sec_n = sec_ext;
				end else begin
					rep_month    = 1'b1;
					snap_year_n  = item.clock_year;
					snap_month_n = item.clock_month;
					snap_day_n   = item.clock_day;
					snap_valid_n = 1'b1;
				end
			end else if (!mode_n && sec_ext != drawn_sec_n) begin
				advance     = 1'b1;
				drawn_sec_n = sec_ext;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= 1'b0;
			year_ofs_q    <= 7'd0;
			disp_month_q  <= MONTH_FIRST;
			mode_was_q    <= 1'b0;
			back_was_q    <= 1'b0;
			fwd_was_q     <= 1'b0;
			press_start_q <= 32'd0;
			last_step_q   <= 32'd0;
			snap_valid_q  <= 1'b0;
			snap_year_q   <= 7'd0;
			snap_month_q  <= 4'd0;
			snap_day_q    <= 5'd0;
			drawn_sec_q   <= SECOND_NONE;
		end else if (step && item.clock_read_ok) begin
			mode_q        <= mode_n;
			year_ofs_q    <= year_ofs_n;
			disp_month_q  <= disp_month_n;
			mode_was_q    <= mk;
			back_was_q    <= bk;
			fwd_was_q     <= fk;
			press_start_q <= press_start_n;
			last_step_q   <= last_step_n;
			snap_valid_q  <= snap_valid_n;
			snap_year_q   <= snap_year_n;
			snap_month_q  <= snap_month_n;
			snap_day_q    <= snap_day_n;
			drawn_sec_q   <= drawn_sec_n;
		end
	end

	always_comb begin
		res.in_month_view      = mode_n;
		res.shown_year         = YEAR_BASE + {5'd0, year_ofs_n};
		res.shown_month        = disp_month_n;
		res.repaint_month      = rep_month;
		res.repaint_dial       = rep_dial;
		res.resync_hands       = resync;
		res.advance_hands      = advance;
		res.refresh_date_panel = panel;
	end

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		disp_month_q >= MONTH_FIRST && disp_month_q <= MONTH_LAST)
		else $error("viewed month left 1..12");

	a_year_range: assert property (@(posedge clk) disable iff (!arst_n)
		year_ofs_q <= YEAR_OFS_MAX)
		else $error("viewed year left 2000..2099");

	a_bad_read_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		step && !item.clock_read_ok |=> $stable(mode_q) && $stable(disp_month_q) &&
		$stable(year_ofs_q) && $stable(drawn_sec_q))
		else $error("invalid clock read changed state");

	a_dial_only_clock: assert property (@(posedge clk) disable iff (!arst_n)
		step && (res.repaint_dial || res.advance_hands || res.refresh_date_panel)
		|-> !res.in_month_view)
		else $error("clock face request raised in month view");

	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		!(back_step && fwd_step))
		else $error("two month steps in one tick");

endmodule

// ===== hdl/clock_calendar_key_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_calendar_key_controller: mode and month-view key handling
// Each request on the s_ side is one poll tick of a clock display; each
// request on the m_ side is the mode, viewed month and redraw flags for it.
//
// Usage:
//   s_tdata carries one tick, m_tdata returns one result per tick, in order.
//   cfg_we/cfg_index/cfg_wdata write the key polarity and timing registers;
//   write them only while no tick is in flight.
//   Path: an accepted tick is captured in the input register, is evaluated
//   against the controller state and its result is registered in the output
//   register that drives m_tvalid.
//   Throughput: one tick per cycle while m_tready is high; the state update
//   for a tick is a single compare-and-update pass, so back-to-back ticks
//   see each other's state. When m_tready is low the finished result holds
//   in the output register and one more tick is still taken into the input
//   register; s_tready then drops until the result is taken.
//   Reset: clock view, 2000-01 viewed, no key held, no date snapshot, no
//   second drawn, and registers at their default timing.
// ----------------------------------------------------------------------------
module clock_calendar_key_controller
	import ccal_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// now_ms[31:0], clock_read_ok[32], mode_key_level[33], back_key_level[34],
	// forward_key_level[35], clock_year[42:36], clock_month[46:43],
	// clock_day[51:47], clock_second[57:52], sync_done[58], zero fill
	input  logic [InDataW-1:0]   s_tdata,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// in_month_view[0], shown_year[12:1], shown_month[16:13],
	// repaint_month[17], repaint_dial[18], resync_hands[19],
	// advance_hands[20], refresh_date_panel[21], zero fill
	output logic [OutDataW-1:0]  m_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic                 cfg_we,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [CfgDataW-1:0]  cfg_wdata
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    proc;

	ccal_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cfg      (cfg)
	);

	assign proc     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.now_ms            <= s_tdata[31:0];
			item_s1.clock_read_ok     <= s_tdata[32];
			item_s1.mode_key_level    <= s_tdata[33];
			item_s1.back_key_level    <= s_tdata[34];
			item_s1.forward_key_level <= s_tdata[35];
			item_s1.clock_year        <= s_tdata[42:36];
			item_s1.clock_month       <= s_tdata[46:43];
			item_s1.clock_day         <= s_tdata[51:47];
			item_s1.clock_second      <= s_tdata[57:52];
			item_s1.sync_done         <= s_tdata[58];
		end
	end

	ccal_core u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (proc),
		.cfg   (cfg),
		.item  (item_s1),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00,
	                   res_q.refresh_date_panel,
	                   res_q.advance_hands,
	                   res_q.resync_hands,
	                   res_q.repaint_dial,
	                   res_q.repaint_month,
	                   res_q.shown_month,
	                   res_q.shown_year,
	                   res_q.in_month_view};

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for clock_calendar_key_controller
// Drives poll ticks into the stream input and predicts each result from a
// cycle-free copy of the controller state. Directed cases cover mode press
// timing, month stepping with lockout and year clamps, and clock read and
// sync handling. A long output stall follows; random traffic then runs under
// several register settings and handshake idling mixes.
// ----------------------------------------------------------------------------
module testbench
	import ccal_pkg::*;
();

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 80;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic [InDataW-1:0]   s_tdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [OutDataW-1:0]  m_tdata;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CfgIndexW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0]  cfg_wdata = '0;

	clock_calendar_key_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Register copies as the controller should hold them.
	bit        key_low_active = KEYS_ACTIVE_LOW_RST;
	bit [15:0] press_min      = SHORT_MIN_RST;
	bit [15:0] press_max      = SHORT_MAX_RST;
	bit [15:0] step_lockout   = NAV_LOCKOUT_RST;

	// Controller state as predicted.
	bit        month_view    = 1'b0;
	bit [6:0]  view_year_ofs = '0;
	bit [3:0]  disp_month    = MONTH_FIRST;
	bit        mode_held     = 1'b0;
	bit [31:0] press_t0      = '0;
	bit        back_held     = 1'b0;
	bit        fwd_held      = 1'b0;
	bit [31:0] step_t0       = '0;
	bit        snap_ok       = 1'b0;
	bit [6:0]  snap_year     = '0;
	bit [3:0]  snap_month    = '0;
	bit [4:0]  snap_day      = '0;
	bit [7:0]  drawn_second  = SECOND_NONE;

	// Stimulus-side wall clock and calendar.
	bit [31:0] now_t = '0;
	bit [6:0]  cal_y = 7'd25;
	bit [3:0]  cal_m = 4'd6;
	bit [4:0]  cal_d = 5'd15;
	bit [5:0]  cal_s = 6'd0;

	result_t pending_displays[$];
	result_t seen_display;
	result_t want_display;

	int send_idle_pct = 0;
	int rcv_stall_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int sent_count = 0;
	int checked_count = 0;
	int mismatches = 0;
	int settings_applied = 0;

	function automatic logic [InDataW-1:0] pack_tick(item_t t);
		logic [InDataW-1:0] d;
		d = '0;
		d[31:0]  = t.now_ms;
		d[32]    = t.clock_read_ok;
		d[33]    = t.mode_key_level;
		d[34]    = t.back_key_level;
		d[35]    = t.forward_key_level;
		d[42:36] = t.clock_year;
		d[46:43] = t.clock_month;
		d[51:47] = t.clock_day;
		d[57:52] = t.clock_second;
		d[58]    = t.sync_done;
		return d;
	endfunction

	function automatic void take_snapshot(item_t t);
		snap_ok    = 1'b1;
		snap_year  = t.clock_year;
		snap_month = t.clock_month;
		snap_day   = t.clock_day;
	endfunction

	function automatic void step_view(bit fwd);
		int y;
		int m;
		y = view_year_ofs;
		m = fwd ? disp_month + 1 : disp_month - 1;
		if (m < int'(MONTH_FIRST)) begin
			m = MONTH_LAST;
			y--;
		end
		if (m > int'(MONTH_LAST)) begin
			m = MONTH_FIRST;
			y++;
		end
		if (y < 0) begin
			y = 0;
			m = MONTH_FIRST;
		end
		if (y > int'(YEAR_OFS_MAX)) begin
			y = YEAR_OFS_MAX;
			m = MONTH_LAST;
		end
		view_year_ofs = 7'(y);
		disp_month = 4'(m);
	endfunction

	// Advances the predicted state by one poll tick and returns its display result.
	function automatic result_t compute_display(item_t t);
		result_t r;
		bit mode_dn;
		bit back_dn;
		bit fwd_dn;
		bit [31:0] held;
		r = '0;
		if (t.clock_read_ok) begin
			mode_dn = t.mode_key_level ^ key_low_active;
			back_dn = t.back_key_level ^ key_low_active;
			fwd_dn  = t.forward_key_level ^ key_low_active;
			if (mode_dn && !mode_held)
				press_t0 = t.now_ms;
			if (!mode_dn && mode_held) begin
				held = t.now_ms - press_t0;
				if (held >= press_min && held < press_max) begin
					if (!month_view) begin
						month_view = 1'b1;
						view_year_ofs = t.clock_year % CENTURY;
						if (t.clock_month < MONTH_FIRST)
							disp_month = MONTH_FIRST;
						else if (t.clock_month > MONTH_LAST)
							disp_month = MONTH_LAST;
						else
							disp_month = t.clock_month;
						r.repaint_month = 1'b1;
						take_snapshot(t);
					end else begin
						month_view = 1'b0;
						r.repaint_dial = 1'b1;
						r.resync_hands = 1'b1;
						drawn_second = {2'b00, t.clock_second};
						snap_ok = 1'b0;
					end
				end
			end
			mode_held = mode_dn;
			if (month_view) begin
				// A step restarts the lockout, so a second step in the same tick is refused.
				if (back_dn && !back_held && (t.now_ms - step_t0) > step_lockout) begin
					step_view(1'b0);
					r.repaint_month = 1'b1;
					step_t0 = t.now_ms;
				end
				if (fwd_dn && !fwd_held && (t.now_ms - step_t0) > step_lockout) begin
					step_view(1'b1);
					r.repaint_month = 1'b1;
					step_t0 = t.now_ms;
				end
				if (snap_ok && (t.clock_year != snap_year || t.clock_month != snap_month ||
						t.clock_day != snap_day)) begin
					take_snapshot(t);
					r.repaint_month = 1'b1;
				end
			end else begin
				r.refresh_date_panel = 1'b1;
			end
			back_held = back_dn;
			fwd_held = fwd_dn;
			if (t.sync_done) begin
				if (!month_view) begin
					r.resync_hands = 1'b1;
					drawn_second = {2'b00, t.clock_second};
				end else begin
					r.repaint_month = 1'b1;
					take_snapshot(t);
				end
			end else if (!month_view && {2'b00, t.clock_second} != drawn_second) begin
				r.advance_hands = 1'b1;
				drawn_second = {2'b00, t.clock_second};
			end
		end
		r.in_month_view = month_view;
		r.shown_year = YEAR_BASE + 12'(view_year_ofs);
		r.shown_month = disp_month;
		return r;
	endfunction

	function automatic void check_field(string name, logic [11:0] want, logic [11:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	function automatic item_t make_tick(bit mode_dn, bit back_dn, bit fwd_dn);
		item_t t;
		t.now_ms            = now_t;
		t.clock_read_ok     = 1'b1;
		t.mode_key_level    = mode_dn ^ key_low_active;
		t.back_key_level    = back_dn ^ key_low_active;
		t.forward_key_level = fwd_dn ^ key_low_active;
		t.clock_year        = cal_y;
		t.clock_month       = cal_m;
		t.clock_day         = cal_d;
		t.clock_second      = cal_s;
		t.sync_done         = 1'b0;
		return t;
	endfunction

	task automatic send_tick(input item_t t);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pack_tick(t);
		do @(posedge clk); while (!s_tready);
		pending_displays.push_back(compute_display(t));
		sent_count++;
	endtask

	task automatic tick_keys(bit mode_dn, bit back_dn, bit fwd_dn, int unsigned dt);
		now_t += dt;
		send_tick(make_tick(mode_dn, back_dn, fwd_dn));
	endtask

	task automatic press_mode(int unsigned hold);
		tick_keys(1'b1, 1'b0, 1'b0, 0);
		tick_keys(1'b0, 1'b0, 1'b0, hold);
	endtask

	task automatic jump_past_lockout(int unsigned extra);
		now_t = step_t0 + step_lockout + extra;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_displays.size() != 0);
	endtask

	task automatic apply_settings(bit low_active, bit [15:0] smin, bit [15:0] smax,
			bit [15:0] lock);
		drain_results();
		// Let the last tick clear the input and state registers before writing.
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_KEYS_ACTIVE_LOW;
		cfg_wdata <= {15'd0, low_active};
		@(posedge clk);
		cfg_index <= REG_SHORT_PRESS_MIN_MS;
		cfg_wdata <= smin;
		@(posedge clk);
		cfg_index <= REG_SHORT_PRESS_MAX_MS;
		cfg_wdata <= smax;
		@(posedge clk);
		cfg_index <= REG_NAV_LOCKOUT_MS;
		cfg_wdata <= lock;
		@(posedge clk);
		cfg_we <= 1'b0;
		key_low_active = low_active;
		press_min = smin;
		press_max = smax;
		step_lockout = lock;
		settings_applied++;
	endtask

	task automatic drift_calendar();
		if ($urandom_range(99) < 60)
			cal_s = (cal_s >= 6'd59) ? 6'd0 : cal_s + 6'd1;
		if ($urandom_range(99) < 8) begin
			cal_y = 7'($urandom_range(99));
			cal_m = 4'($urandom_range(12, 1));
			cal_d = 5'($urandom_range(31, 1));
		end
		if ($urandom_range(99) < 3) begin
			cal_y = 7'($urandom);
			cal_m = 4'($urandom);
			cal_d = 5'($urandom);
			cal_s = 6'($urandom);
		end
	endtask

	task automatic quiet_tick();
		item_t t;
		now_t += $urandom_range(1500);
		drift_calendar();
		t = make_tick(1'b0, 1'b0, 1'b0);
		if ($urandom_range(99) < 6)
			t.sync_done = 1'b1;
		if ($urandom_range(99) < 5)
			t.clock_read_ok = 1'b0;
		send_tick(t);
	endtask

	task automatic noise_tick();
		item_t t;
		if ($urandom_range(3) == 0)
			now_t = $urandom;
		else
			now_t += $urandom_range(2000);
		t.now_ms = now_t;
		{t.clock_read_ok, t.mode_key_level, t.back_key_level, t.forward_key_level,
			t.sync_done} = 5'($urandom);
		t.clock_year = 7'($urandom);
		t.clock_month = 4'($urandom);
		t.clock_day = 5'($urandom);
		t.clock_second = 6'($urandom);
		send_tick(t);
	endtask

	task automatic mode_press_random();
		int unsigned hold;
		int unsigned part;
		int unsigned mids;
		if (press_min < press_max && $urandom_range(3) != 0) begin
			hold = $urandom_range(press_max - 1, press_min);
		end else begin
			case ($urandom_range(2))
				0: hold = 32'(press_min) - 1;
				1: hold = press_max;
				default: hold = $urandom_range(200000);
			endcase
		end
		mids = $urandom_range(2);
		part = hold / (mids + 1);
		drift_calendar();
		tick_keys(1'b1, 1'b0, 1'b0, 0);
		repeat (mids) begin
			drift_calendar();
			tick_keys(1'b1, 1'b0, 1'b0, part);
		end
		drift_calendar();
		tick_keys(1'b0, 1'b0, 1'b0, hold - part * mids);
	endtask

	task automatic nav_press();
		int unsigned k;
		bit b;
		bit f;
		k = $urandom_range(9);
		b = (k < 5);
		f = (k >= 4);
		case ($urandom_range(3))
			0: jump_past_lockout(0);
			1: jump_past_lockout(1);
			default: now_t += $urandom_range(1000);
		endcase
		drift_calendar();
		tick_keys(1'b0, b, f, 0);
		drift_calendar();
		tick_keys(1'b0, 1'b0, 1'b0, $urandom_range(300));
	endtask

	task automatic run_traffic(int n);
		int target;
		int unsigned pick;
		target = sent_count + n;
		while (sent_count < target) begin
			pick = $urandom_range(99);
			if (pick < 25)
				mode_press_random();
			else if (pick < 60 && month_view)
				nav_press();
			else if (pick < 90)
				quiet_tick();
			else
				noise_tick();
		end
	endtask

	task automatic test_clock_face();
		item_t t;
		now_t = '0;
		tick_keys(1'b0, 1'b0, 1'b0, 0);
		// An invalid read with every key down and all fields at zero changes nothing.
		t = make_tick(1'b1, 1'b1, 1'b1);
		t.clock_read_ok = 1'b0;
		t.clock_year = '0;
		t.clock_month = '0;
		t.clock_day = '0;
		t.clock_second = '0;
		t.sync_done = 1'b1;
		send_tick(t);
		t = make_tick(1'b0, 1'b0, 1'b0);
		t.now_ms = '1;
		t.clock_year = '1;
		t.clock_month = '1;
		t.clock_day = '1;
		t.clock_second = '1;
		t.sync_done = 1'b1;
		send_tick(t);
		tick_keys(1'b0, 1'b0, 1'b0, 0);
		tick_keys(1'b0, 1'b0, 1'b0, 10);
	endtask

	task automatic test_mode_key();
		now_t = 32'd1000;
		press_mode(press_min - 1);
		press_mode(press_max);
		cal_y = 7'd127;
		cal_m = 4'd0;
		press_mode(press_min);
		// The hold straddles the wrap of the millisecond counter.
		now_t = 32'hFFFF_FF00;
		press_mode(press_max - 1);
		cal_y = 7'd99;
		cal_m = 4'd15;
		press_mode(500);
	endtask

	task automatic test_month_nav();
		item_t t;
		jump_past_lockout(1);
		tick_keys(1'b0, 1'b0, 1'b1, 0);
		tick_keys(1'b0, 1'b0, 1'b0, 5);
		jump_past_lockout(0);
		tick_keys(1'b0, 1'b1, 1'b0, 0);
		tick_keys(1'b0, 1'b0, 1'b0, 1);
		tick_keys(1'b0, 1'b1, 1'b0, 0);
		tick_keys(1'b0, 1'b0, 1'b0, 1);
		jump_past_lockout(1);
		tick_keys(1'b0, 1'b1, 1'b1, 0);
		cal_d = 5'd16;
		tick_keys(1'b0, 1'b0, 1'b0, 3);
		now_t += 1;
		t = make_tick(1'b0, 1'b0, 1'b0);
		t.sync_done = 1'b1;
		send_tick(t);
		cal_y = 7'd0;
		cal_m = 4'd1;
		press_mode(100);
		press_mode(100);
		jump_past_lockout(1);
		tick_keys(1'b0, 1'b1, 1'b0, 0);
		tick_keys(1'b0, 1'b0, 1'b0, 1);
	endtask

	task automatic test_output_stall();
		// The receiver holds off while requests keep coming until the input stalls.
		hold_requests++;
		repeat (30) quiet_tick();
		drain_results();
	endtask

	task automatic test_random_traffic();
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
				1: begin send_idle_pct = 47; rcv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  rcv_stall_pct = 47; end
				default: begin send_idle_pct = 36; rcv_stall_pct = 36; end
			endcase
			for (int k = 0; k < 2; k++) begin
				case (ph * 2 + k)
					0: apply_settings(1'b1, SHORT_MIN_RST, SHORT_MAX_RST, NAV_LOCKOUT_RST);
					1: apply_settings(1'b0, 16'd0, 16'hFFFF, 16'd0);
					2: apply_settings(1'b1, 16'hFFFF, 16'd0, 16'hFFFF);
					3: apply_settings(1'b0, 16'd1, 16'd2, 16'd1);
					4: apply_settings(1'b1, 16'd0, 16'd0, 16'hFFFF);
					5: apply_settings(1'b0, 16'hFFFE, 16'hFFFF, 16'hFFFE);
					default: apply_settings(1'($urandom), 16'($urandom_range(300)),
						16'($urandom_range(2300, 300)), 16'($urandom_range(1000)));
				endcase
				run_traffic(86);
			end
		end
		send_idle_pct = 0;
		rcv_stall_pct = 0;
	endtask

	always @(posedge clk) begin
		if (hold_requests != hold_served) begin
			hold_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			seen_display.in_month_view      = m_tdata[0];
			seen_display.shown_year         = m_tdata[12:1];
			seen_display.shown_month        = m_tdata[16:13];
			seen_display.repaint_month      = m_tdata[17];
			seen_display.repaint_dial       = m_tdata[18];
			seen_display.resync_hands       = m_tdata[19];
			seen_display.advance_hands      = m_tdata[20];
			seen_display.refresh_date_panel = m_tdata[21];
			if (pending_displays.size() == 0) begin
				$error("result with no tick outstanding: m_tdata=%h", m_tdata);
				mismatches++;
			end else begin
				want_display = pending_displays.pop_front();
				check_field("in_month_view", want_display.in_month_view,
					seen_display.in_month_view);
				check_field("shown_year", want_display.shown_year, seen_display.shown_year);
				check_field("shown_month", want_display.shown_month, seen_display.shown_month);
				check_field("repaint_month", want_display.repaint_month,
					seen_display.repaint_month);
				check_field("repaint_dial", want_display.repaint_dial,
					seen_display.repaint_dial);
				check_field("resync_hands", want_display.resync_hands,
					seen_display.resync_hands);
				check_field("advance_hands", want_display.advance_hands,
					seen_display.advance_hands);
				check_field("refresh_date_panel", want_display.refresh_date_panel,
					seen_display.refresh_date_panel);
				checked_count++;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("** clock_calendar_key_controller: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_clock_face();
		test_mode_key();
		test_month_nav();
		test_output_stall();
		test_random_traffic();
		drain_results();
		repeat (8) @(posedge clk);
		$display("Ran %0d poll ticks, %0d results compared: mode press timing, month steps",
			sent_count, checked_count);
		$display("with lockout and clamps, %0d register settings, four idling mixes, one stall.",
			settings_applied);
		if (mismatches == 0 && pending_displays.size() == 0) begin
			$display("** clock_calendar_key_controller: PASSED **");
		end else begin
			$display("** clock_calendar_key_controller: FAILED **");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/ccal_pkg.sv
hdl/ccal_cfg.sv
hdl/ccal_core.sv
hdl/clock_calendar_key_controller.sv
sim/testbench.sv
